FILE: design/ffha_pkg.sv
// Shared types, widths and helpers for the first-fit heap allocator.
package ffha_pkg;

	localparam int PTR_W = 15;
	localparam int REQ_W = 16;
	localparam int HDR_W = 16;
	localparam int OFF_W = 17;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// bytes taken by a chunk for a request: whole words plus the header word
	function automatic logic [OFF_W-1:0] need_bytes(input logic [REQ_W-1:0] req);
		logic [OFF_W-1:0] r;
		r = OFF_W'(req) + OFF_W'(3);
		r[1:0] = 2'b00;
		return r + OFF_W'(4);
	endfunction

endpackage

FILE: design/ffha_hdr_mem.sv
// Chunk header memory: one write port, one registered read port.
module ffha_hdr_mem #(
	parameter int DEPTH = 4096
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_idx,
	input  logic [ffha_pkg::HDR_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_idx,
	output logic [ffha_pkg::HDR_W-1:0] rd_data
);
	import ffha_pkg::*;

	logic [HDR_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_idx];
		end
	end

endmodule

FILE: design/first_fit_heap_allocator.sv
// First-fit heap allocator top level: header walk sequencer around the header memory.
//
// One request at a time. An allocate walks the heap from the base and reads one chunk
// header per visit, in a read state then an evaluate state, for N headers visited (N at
// most HEAP_WORDS). The one header read port and the shared offset adder set that pace. busy
// is high from the cycle after start is taken until the result; done pulses for one cycle
// with result_pointer and alloc_failed, and the receiver cannot stall it. After reset the
// heap is empty and needs no clearing pass.
module first_fit_heap_allocator #(
	parameter int HEAP_WORDS = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [ffha_pkg::REQ_W-1:0] request_bytes,
	input  logic [ffha_pkg::PTR_W-1:0] release_pointer,
	output logic                       done,
	output logic [ffha_pkg::PTR_W-1:0] result_pointer,
	output logic                       alloc_failed
);
	import ffha_pkg::*;

	localparam int AW = $clog2(HEAP_WORDS);
	localparam int SW = $clog2(HEAP_WORDS + 1);
	localparam logic [OFF_W:0]   HEAP_BYTES_L = (OFF_W + 1)'(HEAP_WORDS * 4);
	localparam logic [OFF_W-3:0] WORDS_L      = (OFF_W - 2)'(HEAP_WORDS);
	localparam logic [SW-1:0]    STEPS_MAX    = SW'(HEAP_WORDS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_EVAL,
		S_A_TAKE,
		S_A_GROW,
		S_R_CHK,
		S_R_MARK,
		S_R_NEXT,
		S_R_MERGE
	} state_t;

	state_t           state_q;
	logic             op_q;
	logic [PTR_W-1:0] ptr_q;
	logic [OFF_W-1:0] need_q;
	logic [OFF_W-1:0] chunk_q;
	logic [OFF_W-1:0] next_q;
	logic [HDR_W-1:0] csize_q;
	logic [PTR_W-1:0] top_q;
	logic [SW-1:0]    steps_q;
	logic             done_q;
	logic [PTR_W-1:0] result_q;
	logic             fail_q;

	logic [HDR_W-1:0] rd_data;
	logic [HDR_W-1:0] h_csize;
	logic             h_free;
	logic             fits;
	logic [OFF_W-1:0] opa;
	logic [OFF_W-1:0] opb;
	logic [OFF_W:0]   sum;
	logic [PTR_W-1:0] rel_chunk;
	logic             rel_ok;

	logic             wr_req;
	logic [OFF_W-1:0] wr_off;
	logic [HDR_W-1:0] wr_data;
	logic             wr_en;
	logic             rd_en;
	logic [OFF_W-1:0] rd_off;

	assign h_csize   = {rd_data[HDR_W-1:1], 1'b0};
	assign h_free    = rd_data[0];
	assign fits      = h_free && ({1'b0, h_csize} >= need_q);
	assign rel_chunk = ptr_q - PTR_W'(4);
	assign rel_ok    = (ptr_q != '0) && (ptr_q[1:0] == 2'b00) && (rel_chunk < top_q);

	// shared offset adder
	always_comb begin
		opa = chunk_q;
		opb = {1'b0, csize_q};
		unique case (state_q)
			S_A_EVAL: begin
				opa = chunk_q;
				opb = fits ? need_q : {1'b0, h_csize};
			end
			S_A_GROW: begin
				opa = {2'b00, top_q};
				opb = need_q;
			end
			S_R_MARK: begin
				opa = chunk_q;
				opb = {1'b0, h_csize};
			end
			S_R_MERGE: begin
				opa = {1'b0, csize_q | HDR_W'(1)};
				opb = {1'b0, rd_data[HDR_W-1:1], 1'b0};
			end
			default: begin
				opa = chunk_q;
				opb = {1'b0, csize_q};
			end
		endcase
	end

	assign sum = {1'b0, opa} + {1'b0, opb};

	// header memory port control
	always_comb begin
		wr_req  = 1'b0;
		wr_off  = chunk_q;
		wr_data = need_q[HDR_W-1:0];
		rd_en   = 1'b0;
		rd_off  = chunk_q;
		unique case (state_q)
			S_A_RD: begin
				rd_en = (chunk_q < {2'b00, top_q}) && (steps_q < STEPS_MAX);
			end
			S_A_EVAL: begin
				wr_req  = (h_csize != '0) && fits && ({1'b0, h_csize} > need_q);
				wr_off  = sum[OFF_W-1:0];
				wr_data = (h_csize - need_q[HDR_W-1:0]) | HDR_W'(1);
			end
			S_A_TAKE: begin
				wr_req  = 1'b1;
			end
			S_A_GROW: begin
				wr_req  = (sum <= HEAP_BYTES_L);
				wr_off  = {2'b00, top_q};
			end
			S_R_CHK: begin
				rd_en   = rel_ok;
				rd_off  = {2'b00, rel_chunk};
			end
			S_R_MARK: begin
				wr_req  = 1'b1;
				wr_data = h_csize | HDR_W'(1);
			end
			S_R_NEXT: begin
				rd_en   = (next_q < {2'b00, top_q});
				rd_off  = next_q;
			end
			S_R_MERGE: begin
				wr_req  = h_free;
				wr_data = sum[HDR_W-1:0];
			end
			default: begin
				wr_req  = 1'b0;
			end
		endcase
	end

	assign wr_en = wr_req && (wr_off[OFF_W-1:2] < WORDS_L);

	ffha_hdr_mem #(
		.DEPTH(HEAP_WORDS)
	) u_hdr_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_idx (wr_off[AW+1:2]),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_idx (rd_off[AW+1:2]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= 1'b0;
			ptr_q    <= '0;
			need_q   <= '0;
			chunk_q  <= '0;
			next_q   <= '0;
			csize_q  <= '0;
			top_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
			fail_q   <= 1'b0;
			steps_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= op;
						ptr_q    <= release_pointer;
						need_q   <= need_bytes(request_bytes);
						chunk_q  <= '0;
						steps_q  <= '0;
						result_q <= '0;
						fail_q   <= 1'b0;
						state_q  <= (op_t'(op) == OP_RELEASE) ? S_R_CHK : S_A_RD;
					end
				end
				S_A_RD: begin
					state_q <= rd_en ? S_A_EVAL : S_A_GROW;
				end
				S_A_EVAL: begin
					steps_q <= steps_q + SW'(1);
					if (h_csize == '0) begin
						state_q <= S_A_GROW;
					end else if (!fits) begin
						chunk_q <= sum[OFF_W-1:0];
						state_q <= S_A_RD;
					end else begin
						state_q <= S_A_TAKE;
					end
				end
				S_A_TAKE: begin
					result_q <= chunk_q[PTR_W-1:0] + PTR_W'(4);
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_A_GROW: begin
					if (sum > HEAP_BYTES_L) begin
						fail_q <= 1'b1;
					end else begin
						top_q    <= sum[PTR_W-1:0];
						result_q <= top_q + PTR_W'(4);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_R_CHK: begin
					chunk_q <= {2'b00, rel_chunk};
					if (rel_ok) begin
						state_q <= S_R_MARK;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_R_MARK: begin
					csize_q <= h_csize;
					next_q  <= sum[OFF_W-1:0];
					state_q <= S_R_NEXT;
				end
				S_R_NEXT: begin
					if (rd_en) begin
						state_q <= S_R_MERGE;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_R_MERGE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign result_pointer = result_q;
	assign alloc_failed   = fail_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but sequencer stayed idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	a_fail_null: assert property (@(posedge clk) disable iff (!arst_n)
		(done && alloc_failed) |-> (result_pointer == '0))
		else $error("failed allocate returned a pointer");

	a_release_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_t'(op_q) == OP_RELEASE) |-> (!alloc_failed && result_pointer == '0))
		else $error("release returned a pointer or failure");

endmodule
